FILE: rtl/core/oale_pkg.sv
// Package for the ordered array list engine.
// Store sizing, field widths, request and status codes, shared structs.
// No dependencies.
package oale_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int MODE_W = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 3;
  localparam int FIDX_W = 6;
  localparam int ECNT_W = 7;
  localparam int RCNT_W = 7;

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int IN_FIELDS_W  = POS_W + 2 * VAL_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = FIDX_W + ECNT_W + RCNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_INSERT     = 3'd4,
    MODE_ERASE      = 3'd5,
    MODE_FIND       = 3'd6,
    MODE_REPLACE    = 3'd7
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BADPOS   = 3'd4
  } status_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;
  } mem_req_t;

  typedef struct packed {
    status_t           status;
    logic [FIDX_W-1:0] found_index;
    logic [ECNT_W-1:0] element_count;
    logic [RCNT_W-1:0] replaced_count;
  } result_t;

endpackage

FILE: rtl/core/ordered_array_list_engine_core.sv
// Ordered array list engine: top level with entry store, sequencer and
// output item register. Depends on oale_pkg, oale_ram, oale_seq.
// Faults and pop back go from idle straight to finish, push back writes the value first;
// insert, erase, find and replace walk the entries, one store access per cycle. The result
// is held in the output item register; in_tready is high only while idle.
// Reset (sync, active low) empties the list; store contents are not cleared.
module ordered_array_list_engine_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // position, value, new_value, zero pad
  input  logic [oale_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode
  input  logic [oale_pkg::MODE_W-1:0]      in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // found_index, element_count, replaced_count, zero pad
  output logic [oale_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status
  output logic [oale_pkg::STAT_W-1:0]      out_tuser
);

  localparam int VAL_LO  = oale_pkg::POS_W;
  localparam int NVAL_LO = oale_pkg::POS_W + oale_pkg::VAL_W;

  oale_pkg::mem_req_t           mem_req;
  logic [oale_pkg::VAL_W-1:0]   rd_data;
  logic                         res_valid, res_ready;
  oale_pkg::result_t            res;
  logic                         out_valid_r;
  oale_pkg::result_t            out_data_r;

  oale_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .mode      (oale_pkg::mode_t'(in_tuser)),
    .position  (in_tdata[oale_pkg::POS_W-1:0]),
    .value     (in_tdata[VAL_LO +: oale_pkg::VAL_W]),
    .new_value (in_tdata[NVAL_LO +: oale_pkg::VAL_W]),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  oale_ram #(
    .WIDTH (oale_pkg::VAL_W),
    .DEPTH (oale_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_data)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_data_r.status;
  assign out_tdata  = {{oale_pkg::OUT_PAD_W{1'b0}}, out_data_r.replaced_count,
                       out_data_r.element_count, out_data_r.found_index};

endmodule

FILE: rtl/core/oale_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module oale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/oale_seq.sv
// Request sequencer: one entry access per cycle through the store, with a
// single shared compare/move stage for shifts, find and replace.
// Depends on oale_pkg.
module oale_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  oale_pkg::mode_t           mode,
  input  logic [oale_pkg::POS_W-1:0] position,
  input  logic [oale_pkg::VAL_W-1:0] value,
  input  logic [oale_pkg::VAL_W-1:0] new_value,
  output oale_pkg::mem_req_t        mem_req,
  input  logic [oale_pkg::VAL_W-1:0] rd_data,
  output logic                      res_valid,
  input  logic                      res_ready,
  output oale_pkg::result_t         res
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_DRAIN = 5'b00100,
    S_WRV   = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    OP_INS  = 2'd0,
    OP_ERA  = 2'd1,
    OP_FIND = 2'd2,
    OP_REPL = 2'd3
  } op_t;

  state_t                          state_r, state_nxt;
  op_t                             op_r, op_nxt;
  logic [oale_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [oale_pkg::ADDR_W-1:0]     k_r, k_nxt;
  logic [oale_pkg::ADDR_W-1:0]     pos_r, pos_nxt;
  logic [oale_pkg::ADDR_W-1:0]     last_r, last_nxt;
  logic [oale_pkg::VAL_W-1:0]      val_r, val_nxt;
  logic [oale_pkg::VAL_W-1:0]      nval_r, nval_nxt;
  logic                            pend_r, pend_nxt;
  logic [oale_pkg::ADDR_W-1:0]     pend_addr_r, pend_addr_nxt;
  oale_pkg::status_t               status_r, status_nxt;
  logic [oale_pkg::ADDR_W-1:0]     found_r, found_nxt;
  logic [oale_pkg::CNT_W-1:0]      repl_r, repl_nxt;

  logic                            full, empty, hit;
  logic [oale_pkg::CMP_W-1:0]      cmp_pos, cmp_cnt;
  logic [oale_pkg::ADDR_W-1:0]     cnt_a, cnt_m1, p_ins, p_era;
  logic [oale_pkg::CNT_W-1:0]      cnt_new;

  always_comb begin
    full    = (cnt_r == oale_pkg::CNT_W'(oale_pkg::DEPTH));
    empty   = (cnt_r == '0);
    cmp_pos = oale_pkg::CMP_W'(position);
    cmp_cnt = oale_pkg::CMP_W'(cnt_r);
    cnt_a   = oale_pkg::ADDR_W'(cnt_r);
    cnt_m1  = oale_pkg::ADDR_W'(cnt_r - oale_pkg::CNT_W'(1));
    hit     = pend_r && (rd_data == val_r);
    p_ins   = oale_pkg::ADDR_W'(position);
    p_era   = oale_pkg::ADDR_W'(position);
    if (mode == oale_pkg::MODE_PUSH_BACK) begin
      p_ins = cnt_a;
    end else if (mode == oale_pkg::MODE_PUSH_FRONT) begin
      p_ins = '0;
    end
    if (mode == oale_pkg::MODE_POP_BACK) begin
      p_era = cnt_m1;
    end else if (mode == oale_pkg::MODE_POP_FRONT) begin
      p_era = '0;
    end

    cnt_new = cnt_r;
    if (status_r == oale_pkg::ST_OK && op_r == OP_INS) begin
      cnt_new = cnt_r + oale_pkg::CNT_W'(1);
    end else if (status_r == oale_pkg::ST_OK && op_r == OP_ERA) begin
      cnt_new = cnt_r - oale_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;
    val_nxt       = val_r;
    nval_nxt      = nval_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    repl_nxt      = repl_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    mem_req       = '0;

    // pending read data from the previous cycle
    if (pend_r) begin
      unique case (op_r)
        OP_INS, OP_ERA: begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = pend_addr_r;
          mem_req.wr_data = rd_data;
        end
        OP_REPL: begin
          if (hit) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pend_addr_r;
            mem_req.wr_data = nval_r;
            repl_nxt        = repl_r + oale_pkg::CNT_W'(1);
          end
        end
        OP_FIND: begin
          if (hit) begin
            status_nxt = oale_pkg::ST_OK;
            found_nxt  = pend_addr_r;
          end
        end
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          val_nxt    = value;
          nval_nxt   = new_value;
          found_nxt  = '0;
          repl_nxt   = '0;
          status_nxt = oale_pkg::ST_OK;
          k_nxt      = '0;
          last_nxt   = cnt_m1;
          unique case (mode)
            oale_pkg::MODE_PUSH_BACK, oale_pkg::MODE_PUSH_FRONT,
            oale_pkg::MODE_INSERT: begin
              op_nxt  = OP_INS;
              pos_nxt = p_ins;
              if (full) begin
                status_nxt = oale_pkg::ST_FULL;
                state_nxt  = S_FIN;
              end else if (mode == oale_pkg::MODE_INSERT && cmp_pos > cmp_cnt) begin
                status_nxt = oale_pkg::ST_BADPOS;
                state_nxt  = S_FIN;
              end else if (p_ins == cnt_a) begin
                state_nxt = S_WRV;
              end else begin
                k_nxt     = cnt_m1;
                last_nxt  = p_ins;
                state_nxt = S_SHIFT;
              end
            end
            oale_pkg::MODE_POP_BACK, oale_pkg::MODE_POP_FRONT,
            oale_pkg::MODE_ERASE: begin
              op_nxt  = OP_ERA;
              pos_nxt = p_era;
              if (empty) begin
                status_nxt = oale_pkg::ST_EMPTY;
                state_nxt  = S_FIN;
              end else if (mode == oale_pkg::MODE_ERASE && cmp_pos >= cmp_cnt) begin
                status_nxt = oale_pkg::ST_BADPOS;
                state_nxt  = S_FIN;
              end else if (p_era == cnt_m1) begin
                state_nxt = S_FIN;
              end else begin
                k_nxt     = p_era + oale_pkg::ADDR_W'(1);
                state_nxt = S_SHIFT;
              end
            end
            oale_pkg::MODE_FIND: begin
              op_nxt     = OP_FIND;
              status_nxt = oale_pkg::ST_NOTFOUND;
              state_nxt  = empty ? S_FIN : S_SHIFT;
            end
            oale_pkg::MODE_REPLACE: begin
              op_nxt    = OP_REPL;
              state_nxt = empty ? S_FIN : S_SHIFT;
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (op_r == OP_FIND && hit) begin
          state_nxt = S_FIN;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = k_r;
          pend_nxt        = 1'b1;
          unique case (op_r)
            OP_INS:           pend_addr_nxt = k_r + oale_pkg::ADDR_W'(1);
            OP_ERA:           pend_addr_nxt = k_r - oale_pkg::ADDR_W'(1);
            OP_FIND, OP_REPL: pend_addr_nxt = k_r;
          endcase
          if (k_r == last_r) begin
            state_nxt = S_DRAIN;
          end else if (op_r == OP_INS) begin
            k_nxt = k_r - oale_pkg::ADDR_W'(1);
          end else begin
            k_nxt = k_r + oale_pkg::ADDR_W'(1);
          end
        end
      end
      S_DRAIN: begin
        state_nxt = (op_r == OP_INS) ? S_WRV : S_FIN;
      end
      S_WRV: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = pos_r;
        mem_req.wr_data = val_r;
        state_nxt       = S_FIN;
      end
      S_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          cnt_nxt   = cnt_new;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    res.status         = status_r;
    res.found_index    = oale_pkg::FIDX_W'(found_r);
    res.element_count  = oale_pkg::ECNT_W'(cnt_new);
    res.replaced_count = oale_pkg::RCNT_W'(repl_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    k_r         <= k_nxt;
    pos_r       <= pos_nxt;
    last_r      <= last_nxt;
    val_r       <= val_nxt;
    nval_r      <= nval_nxt;
    pend_addr_r <= pend_addr_nxt;
    status_r    <= status_nxt;
    found_r     <= found_nxt;
    repl_r      <= repl_nxt;
  end

endmodule

FILE: rtl/core/oale_checker.sv
// Port-level checker for ordered_array_list_engine_core, bound to the top.
// Depends on oale_pkg.
module oale_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [oale_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [oale_pkg::STAT_W-1:0]      out_tuser
);

  localparam int ECNT_LO = oale_pkg::FIDX_W;

  logic [oale_pkg::ECNT_W-1:0] ecnt;
  assign ecnt = out_tdata[ECNT_LO +: oale_pkg::ECNT_W];

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while previous item still in progress");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == oale_pkg::ST_FULL
      |-> ecnt == oale_pkg::ECNT_W'(oale_pkg::DEPTH))
    else $error("full status with count below capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == oale_pkg::ST_EMPTY |-> ecnt == '0)
    else $error("empty status with nonzero count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output item changed");

endmodule

bind ordered_array_list_engine_core oale_checker u_oale_checker (.*);
